FILE: hw/rtl/slipcrc_pkg.sv
// ----------------------------------------------------------------------------
// slipcrc_pkg
// Shared constants, types and the CRC-16/XMODEM byte update for the SLIP
// frame decoder.
// ----------------------------------------------------------------------------
package slipcrc_pkg;

	localparam logic [7:0] DELIM     = 8'hC0;
	localparam logic [7:0] ESC       = 8'hDB;
	localparam logic [7:0] ESC_END   = 8'hDC;
	localparam logic [7:0] ESC_ESC   = 8'hDD;
	localparam logic [7:0] BROADCAST = 8'hFF;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CRC_ERR = 2'd1;
	localparam logic [1:0] ST_SHORT   = 2'd2;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int Q_DEPTH = 4;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} item_t;

	// up to two results per request, in order: item[0] first
	typedef struct packed {
		logic [1:0]      n;
		item_t [1:0]     item;
	} push_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/slipcrc_outq.sv
// ----------------------------------------------------------------------------
// slipcrc_outq
// Result queue: takes zero, one or two items per cycle, hands out one while out_stall is low.
// ----------------------------------------------------------------------------
module slipcrc_outq #(
	parameter int DEPTH = slipcrc_pkg::Q_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slipcrc_pkg::push_t  push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output slipcrc_pkg::item_t  out_item
);
	import slipcrc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic [PW-1:0]  wr_ptr_nx;
	logic           pop;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_ptr_nx = inc(wr_ptr_q);
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign room      = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.item[0];
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.item[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.n)
				2'd1:    wr_ptr_q <= wr_ptr_nx;
				2'd2:    wr_ptr_q <= inc(wr_ptr_nx);
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule

FILE: hw/rtl/slip_crc_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// slip_crc_frame_decoder_core
// SLIP deframer with address filter and CRC-16/XMODEM check.
// ----------------------------------------------------------------------------
// Takes one line byte per cycle while rx_stall is low. A byte is registered,
// then decoded combinationally (unescape, address filter, two-byte delay,
// CRC update, end-of-frame status) and its zero to two results are written
// to a small result queue. rx_stall rises only when the queue holds more
// than DEPTH-2 results, so with out_stall low the block sustains one byte
// per cycle. listen_address is written through the cfg channel, which is
// always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module slip_crc_frame_decoder_core #(
	parameter int QDEPTH = slipcrc_pkg::Q_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic [1:0] frame_status,
	output logic       last
);
	import slipcrc_pkg::*;

	logic [7:0]  listen_q;
	logic        in_frame_q;
	logic        esc_q;
	logic [7:0]  d0_q;
	logic [7:0]  d1_q;
	logic [1:0]  cnt_q;
	logic        match_q;
	logic [15:0] crc_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        room;
	logic        fire;

	logic        in_frame_n;
	logic        esc_n;
	logic [7:0]  d0_n;
	logic [7:0]  d1_n;
	logic [1:0]  cnt_n;
	logic        match_n;
	logic [15:0] crc_n;
	push_t       res;
	push_t       push;
	item_t       out_item;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && room;
	assign rx_stall  = valid_s1 && !room;

	always_comb begin
		logic [1:0] t_en;
		logic [7:0] t_byte [2];
		logic       close;
		logic       open;
		t_en      = '0;
		t_byte[0] = ESC;
		t_byte[1] = byte_s1;
		close     = 1'b0;
		open      = 1'b0;
		in_frame_n = in_frame_q;
		esc_n   = esc_q;
		d0_n    = d0_q;
		d1_n    = d1_q;
		cnt_n   = cnt_q;
		match_n = match_q;
		crc_n   = crc_q;
		res     = '0;

		if (!in_frame_q) begin
			if (byte_s1 == DELIM) begin
				in_frame_n = 1'b1;
				open       = 1'b1;
			end
		end else if (byte_s1 == DELIM) begin
			t_en[0] = esc_q;
			close   = 1'b1;
		end else if (esc_q) begin
			esc_n = 1'b0;
			if (byte_s1 == ESC_END) begin
				t_en[0]   = 1'b1;
				t_byte[0] = DELIM;
			end else if (byte_s1 == ESC_ESC) begin
				t_en[0] = 1'b1;
			end else begin
				// unknown escape: literal DB, then the byte as usual
				t_en[0] = 1'b1;
				if (byte_s1 == ESC) begin
					esc_n = 1'b1;
				end else begin
					t_en[1] = 1'b1;
				end
			end
		end else if (byte_s1 == ESC) begin
			esc_n = 1'b1;
		end else begin
			t_en[1] = 1'b1;
		end

		for (int k = 0; k < 2; k++) begin
			if (t_en[k]) begin
				if (cnt_n == 2'd0) begin
					match_n = (t_byte[k] == listen_q) || (listen_q == BROADCAST);
				end
				if (cnt_n >= 2'd2) begin
					crc_n = crc_step(crc_n, d1_n);
					if (match_n) begin
						res.item[res.n[0]] = '{kind: KIND_BYTE, data: d1_n,
							status: ST_OK, last: 1'b0};
						res.n = res.n + 2'd1;
					end
				end
				d1_n = d0_n;
				d0_n = t_byte[k];
				if (cnt_n != 2'd3) begin
					cnt_n = cnt_n + 2'd1;
				end
			end
		end

		if (close && cnt_n != 2'd0 && match_n) begin
			res.item[res.n[0]] = '{kind: KIND_STATUS, data: 8'h00,
				status: (cnt_n != 2'd3) ? ST_SHORT :
					(({d0_n, d1_n} == crc_n) ? ST_OK : ST_CRC_ERR),
				last: 1'b1};
			res.n = res.n + 2'd1;
		end

		if (close || open) begin
			esc_n   = 1'b0;
			d0_n    = '0;
			d1_n    = '0;
			cnt_n   = '0;
			match_n = 1'b0;
			crc_n   = '0;
		end
	end

	always_comb begin
		push   = res;
		push.n = fire ? res.n : 2'd0;
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_q   <= BROADCAST;
			valid_s1   <= 1'b0;
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			d0_q       <= '0;
			d1_q       <= '0;
			cnt_q      <= '0;
			match_q    <= 1'b0;
			crc_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				listen_q <= cfg_data;
			end
			if (!rx_stall) begin
				valid_s1 <= rx_valid;
			end
			if (fire) begin
				in_frame_q <= in_frame_n;
				esc_q      <= esc_n;
				d0_q       <= d0_n;
				d1_q       <= d1_n;
				cnt_q      <= cnt_n;
				match_q    <= match_n;
				crc_q      <= crc_n;
			end
		end
	end

	slipcrc_outq #(
		.DEPTH(QDEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign out_kind     = out_item.kind;
	assign out_byte     = out_item.data;
	assign frame_status = out_item.status;
	assign last         = out_item.last;

endmodule

FILE: hw/rtl/slipcrc_chk.sv
// ----------------------------------------------------------------------------
// slipcrc_chk
// Port-level checks for the SLIP frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module slipcrc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       out_kind,
	input logic [7:0] out_byte,
	input logic [1:0] frame_status,
	input logic       last
);
	import slipcrc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
		else $error("result dropped or changed while stalled");

	a_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_STATUS |-> last && out_byte == 8'h00)
		else $error("status item without last or with nonzero byte");

	a_byte_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_BYTE |-> !last && frame_status == ST_OK)
		else $error("byte item with last or status set");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status == ST_OK || frame_status == ST_CRC_ERR ||
			frame_status == ST_SHORT)
		else $error("undefined frame status");

	// input is held back only while results are queued
	a_stall_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> out_valid)
		else $error("request stalled with no result pending");

endmodule

bind slip_crc_frame_decoder_core slipcrc_chk u_slipcrc_chk (.*);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for slip_crc_frame_decoder_core.
// ----------------------------------------------------------------------------
// Line bytes are sent one request at a time. Each accepted byte runs through
// a behavioral deframer with its own escape, address and CRC-16/XMODEM state.
// That deframer queues the decoded byte and status items due, and every
// result is checked field by field against the oldest queued item. Directed
// tests cover hunting, escapes, short and empty frames, unknown escapes, bad
// CRC and the address filter. Random traffic follows: mostly well-formed
// frames with random content, plus bad-CRC, short, empty and noise bursts,
// under several listen addresses and idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import slipcrc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 6;

	typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_RAW} frame_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       out_kind;
	logic [7:0] out_byte;
	logic [1:0] frame_status;
	logic       last;

	// deframer state
	bit         in_frame;
	bit         esc_pending;
	bit [7:0]   hold_new;
	bit [7:0]   hold_old;
	bit [1:0]   n_decoded;
	bit         addr_ok;
	bit [15:0]  crc_acc;
	bit [7:0]   listen_addr = BROADCAST;

	item_t      frame_items_q[$];
	bit [7:0]   frame_body[$];
	int         mismatch_count = 0;
	int         bytes_sent = 0;
	int         cycle_count = 0;
	int         send_gap_pct = 0;
	int         stall_pct = 0;

	slip_crc_frame_decoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.frame_status (frame_status),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---- deframer prediction ----

	function automatic bit [15:0] crc16_update(bit [15:0] crc, bit [7:0] b);
		bit fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	function automatic void clear_frame();
		esc_pending = 0;
		hold_new = 8'h00;
		hold_old = 8'h00;
		n_decoded = 2'd0;
		addr_ok = 0;
		crc_acc = 16'h0000;
	endfunction

	function automatic void push_item(bit kind, bit [7:0] data, bit [1:0] st, bit fin);
		item_t it;
		it.kind = kind;
		it.data = data;
		it.status = st;
		it.last = fin;
		frame_items_q.insert(frame_items_q.size(), it);
	endfunction

	function automatic void take_decoded(bit [7:0] b);
		if (n_decoded == 2'd0) begin
			addr_ok = (b == listen_addr) || (listen_addr == BROADCAST);
		end
		if (n_decoded >= 2'd2) begin
			crc_acc = crc16_update(crc_acc, hold_old);
			if (addr_ok) begin
				push_item(KIND_BYTE, hold_old, ST_OK, 1'b0);
			end
		end
		hold_old = hold_new;
		hold_new = b;
		if (n_decoded < 2'd3) begin
			n_decoded++;
		end
	endfunction

	function automatic void deframe_byte(bit [7:0] b);
		bit [1:0] st;
		if (!in_frame) begin
			if (b == DELIM) begin
				in_frame = 1;
				clear_frame();
			end
			return;
		end
		if (b == DELIM) begin
			if (esc_pending) begin
				esc_pending = 0;
				take_decoded(ESC);
			end
			if (n_decoded != 2'd0 && addr_ok) begin
				if (n_decoded < 2'd3) begin
					st = ST_SHORT;
				end else begin
					st = ({hold_new, hold_old} == crc_acc) ? ST_OK : ST_CRC_ERR;
				end
				push_item(KIND_STATUS, 8'h00, st, 1'b1);
			end
			clear_frame();
			return;
		end
		if (esc_pending) begin
			esc_pending = 0;
			if (b == ESC_END) begin
				take_decoded(DELIM);
				return;
			end
			if (b == ESC_ESC) begin
				take_decoded(ESC);
				return;
			end
			take_decoded(ESC);
		end
		if (b == ESC) begin
			esc_pending = 1;
		end else begin
			take_decoded(b);
		end
	endfunction

	// ---- result check ----

	always @(posedge clk) begin
		item_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (frame_items_q.size() == 0) begin
				$error("unexpected result: out_kind %0d out_byte %h", out_kind, out_byte);
				mismatch_count++;
			end else begin
				want = frame_items_q.pop_front();
				if (out_kind !== want.kind) begin
					$error("out_kind: expected %0d, got %0d", want.kind, out_kind);
					mismatch_count++;
				end
				if (out_byte !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, out_byte);
					mismatch_count++;
				end
				if (frame_status !== want.status) begin
					$error("frame_status: expected %0d, got %0d", want.status, frame_status);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatch_count++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// ---- stimulus helpers ----

	task automatic send_line_byte(input bit [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_gap_pct && gap < 40) begin
			gap++;
		end
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall !== 1'b0);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		while (frame_items_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_listen(input bit [7:0] addr);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		listen_addr = addr;
	endtask

	function automatic bit [7:0] pick_byte();
		case ($urandom_range(7))
			0: return DELIM;
			1: return ESC;
			2: return ESC_END;
			3: return ESC_ESC;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic bit [7:0] pick_address();
		case ($urandom_range(3))
			0, 1: return listen_addr;
			2: return 8'($urandom);
			default: return pick_byte();
		endcase
	endfunction

	// sends frame_body (address first) escaped, plus its CRC unless raw,
	// and the closing delimiter
	task automatic send_frame(input frame_kind_t kind);
		bit [15:0] c;
		bit [7:0] nxt;
		int n;
		if (kind != FRAME_RAW) begin
			c = 16'h0000;
			foreach (frame_body[i]) c = crc16_update(c, frame_body[i]);
			frame_body.insert(frame_body.size(), c[7:0]);
			frame_body.insert(frame_body.size(), c[15:8]);
			if (kind == FRAME_BAD_CRC) begin
				n = frame_body.size() - 1 - $urandom_range(1);
				frame_body[n] ^= 8'h01 << $urandom_range(7);
			end
		end
		foreach (frame_body[i]) begin
			nxt = (i + 1 < frame_body.size()) ? frame_body[i + 1] : DELIM;
			if (frame_body[i] == DELIM) begin
				send_line_byte(ESC);
				send_line_byte(ESC_END);
			end else if (frame_body[i] == ESC) begin
				send_line_byte(ESC);
				// a bare escape still decodes as itself unless DC or DD follows
				if (nxt == ESC_END || nxt == ESC_ESC || $urandom_range(2) != 0) begin
					send_line_byte(ESC_ESC);
				end
			end else begin
				send_line_byte(frame_body[i]);
			end
		end
		send_line_byte(DELIM);
	endtask

	task automatic run_traffic(input int n_bytes);
		int stop_at;
		int r;
		int len;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(99);
			frame_body.delete();
			frame_body.insert(frame_body.size(), pick_address());
			if (r < 80) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
				repeat (len) frame_body.insert(frame_body.size(), pick_byte());
				send_frame(r < 68 ? FRAME_GOOD : FRAME_BAD_CRC);
			end else if (r < 88) begin
				if ($urandom_range(1)) begin
					frame_body.insert(frame_body.size(), pick_byte());
				end
				send_frame(FRAME_RAW);
			end else if (r < 95) begin
				repeat ($urandom_range(1, 6)) send_line_byte(pick_byte());
			end else begin
				send_line_byte(DELIM);
			end
		end
	endtask

	// ---- tests ----

	task automatic test_hunting();
		send_line_byte(ESC);
		send_line_byte(8'hFF);
		send_line_byte(8'h00);
		send_line_byte(DELIM);
	endtask

	task automatic test_frame_escapes();
		frame_body = '{8'h01, DELIM, ESC};
		send_frame(FRAME_GOOD);
	endtask

	task automatic test_short_and_empty();
		send_line_byte(DELIM);
		frame_body = '{8'h33};
		send_frame(FRAME_RAW);
		frame_body = '{8'h33, 8'h44};
		send_frame(FRAME_RAW);
	endtask

	task automatic test_unknown_escape();
		send_line_byte(8'h41);
		send_line_byte(ESC);
		send_line_byte(8'h42);
		send_line_byte(ESC);
		send_line_byte(ESC);
		send_line_byte(ESC_END);
		send_line_byte(ESC);
		send_line_byte(DELIM);
	endtask

	task automatic test_bad_crc();
		frame_body = '{8'h7E, 8'h00, 8'hFF};
		send_frame(FRAME_BAD_CRC);
	endtask

	task automatic test_address_filter();
		set_listen(ESC);
		frame_body = '{ESC, 8'h10};
		send_frame(FRAME_GOOD);
		frame_body = '{8'h5A, 8'h10};
		send_frame(FRAME_GOOD);
	endtask

	task automatic test_random_traffic();
		send_gap_pct = 0;
		stall_pct = 0;
		set_listen(BROADCAST);
		run_traffic(150);
		send_gap_pct = 68;
		stall_pct = 0;
		set_listen(8'h00);
		run_traffic(150);
		send_gap_pct = 0;
		stall_pct = 68;
		set_listen(8'($urandom_range(1, 254)));
		run_traffic(150);
		send_gap_pct = 8;
		stall_pct = 8;
		set_listen(DELIM);
		run_traffic(150);
	endtask

	initial begin
		clear_frame();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hunting();
		test_frame_escapes();
		test_short_and_empty();
		test_unknown_escape();
		test_bad_crc();
		test_address_filter();
		test_random_traffic();
		drain();
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
